// File: rtl/core/smhh_pkg.sv
// Package with shared types, constants and SHA-256 helper functions.
package smhh_pkg;

   localparam int INDEX_BITS = 31;
   localparam int VLEN_BITS  = 7;
   localparam int SLOT_BITS  = 6;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 31;
   localparam int NUM_ROUNDS = 64;
   localparam int NUM_CELLS  = 8;
   localparam int ROUNDS_PER_CELL = NUM_ROUNDS / NUM_CELLS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MOD_N = 1'b0,
      CSR_VLEN  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] a, b, c, d, e, f, g, h;
   } work_type;

   // Carries the request through the cells alongside the working state.
   typedef struct packed {
      logic             valid;
      logic             batch;
      logic [511:0]     sched;
      work_type         work;
   } cell_data_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      round_k = k[i];
   endfunction

   localparam work_type INIT_H = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

// File: rtl/core/smhh_if.sv
// Valid/ready channel interfaces for requests and results.
interface smhh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        batch_end;
   modport source (output valid, value, batch_end, input ready);
   modport sink   (input valid, value, batch_end, output ready);
endinterface

interface smhh_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] index;
   logic [5:0]  slot;
   logic        last;
   logic        batch_last;
   modport source (output valid, index, slot, last, batch_last, input ready);
   modport sink   (input valid, index, slot, last, batch_last, output ready);
endinterface

// File: rtl/core/smhh_msg.sv
// Converts the signed value to decimal ASCII, one digit per cycle, and builds the block.
module smhh_msg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [31:0]             in_value,
   input  logic                    in_batch,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [511:0]            out_block,
   output logic                    out_batch
);
   import smhh_pkg::*;

   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [39:0] digs_ff, digs_in;
   logic [3:0]  nd_ff, nd_in;
   logic        batch_ff, batch_in;
   logic        oval_ff, oval_in;
   logic [511:0] blk_ff, blk_in;
   logic        obatch_ff, obatch_in;
   logic [31:0] quot;
   logic [3:0]  rem;
   logic        done;
   logic [87:0] text;
   logic [3:0]  len;
   logic [63:0] quot_prod;
   logic        out_free;

   // Divide by ten through a reciprocal multiply; the remainder is taken back from the quotient.
   always_comb begin
      logic [35:0] back;
      quot_prod = 64'(mag_ff) * 64'h0000_0000_CCCC_CCCD;
      quot = 32'(quot_prod[63:35]);
      back = 36'(quot) * 36'd10;
      rem  = 4'(mag_ff - back[31:0]);
   end

   assign done     = (quot == '0) || (nd_ff == 4'd9);
   assign out_free = !oval_ff || out_ready;
   assign in_ready = !busy_ff;

   always_comb begin
      int k;
      text = '0;
      len  = 4'(nd_ff + 4'd1) + 4'(neg_ff);
      if (neg_ff) text[87:80] = 8'h2d;
      for (k = 0; k < 10; k++) begin
         if (4'(k) <= nd_ff)
            text[87 - 8 * (int'(neg_ff) + k) -: 8] = 8'h30 | 8'(digs_in[4 * (int'(nd_ff) - k) +: 4]);
      end
   end

   always_comb begin
      busy_in = busy_ff; neg_in = neg_ff; mag_in = mag_ff; digs_in = digs_ff;
      nd_in = nd_ff; batch_in = batch_ff; oval_in = oval_ff; blk_in = blk_ff;
      obatch_in = obatch_ff;
      if (oval_ff && out_ready) oval_in = 1'b0;
      if (busy_ff) begin
         digs_in[4 * nd_ff +: 4] = rem;
      end
      if (!busy_ff && in_valid) begin
         busy_in  = 1'b1;
         neg_in   = in_value[31];
         mag_in   = in_value[31] ? (32'd0 - in_value) : in_value;
         nd_in    = '0;
         batch_in = in_batch;
      end else if (busy_ff) begin
         if (!done) begin
            mag_in = quot;
            nd_in  = nd_ff + 4'd1;
         end else if (out_free) begin
            busy_in   = 1'b0;
            oval_in   = 1'b1;
            obatch_in = batch_ff;
            blk_in    = '0;
            blk_in[511 -: 88] = text;
            blk_in[511 - 8 * int'(len) -: 8] = 8'h80;
            blk_in[15:0] = 16'(len) << 3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         oval_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         oval_ff <= oval_in;
      end
      neg_ff <= neg_in; mag_ff <= mag_in; digs_ff <= digs_in; nd_ff <= nd_in;
      batch_ff <= batch_in; blk_ff <= blk_in; obatch_ff <= obatch_in;
   end

   assign out_valid = oval_ff;
   assign out_block = blk_ff;
   assign out_batch = obatch_ff;
endmodule

// File: rtl/core/smhh_cell.sv
// One compression cell: eight rounds, one per cycle while the chain is not held, on its own slot of the chain.
module smhh_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [2:0]               cell_id,
   input  logic                     advance,
   input  logic                     step_en,
   input  logic [2:0]               step,
   input  smhh_pkg::cell_data_type  prev_data,
   output smhh_pkg::cell_data_type  cell_data
);
   import smhh_pkg::*;

   cell_data_type data_ff, data_in, rounded;
   logic [31:0] w_cur, w_new, t1, t2, s0, s1;
   logic [5:0]  rnd;
   work_type    v;

   assign rnd   = {cell_id, step};
   assign v     = data_ff.work;
   assign w_cur = data_ff.sched[511:480];
   assign s0 = rotr(data_ff.sched[479:448], 7) ^ rotr(data_ff.sched[479:448], 18)
             ^ (data_ff.sched[479:448] >> 3);
   assign s1 = rotr(data_ff.sched[63:32], 17) ^ rotr(data_ff.sched[63:32], 19)
             ^ (data_ff.sched[63:32] >> 10);
   assign w_new = w_cur + s0 + data_ff.sched[223:192] + s1;
   assign t1 = v.h + (rotr(v.e, 6) ^ rotr(v.e, 11) ^ rotr(v.e, 25))
             + ((v.e & v.f) ^ (~v.e & v.g)) + round_k(rnd) + w_cur;
   assign t2 = (rotr(v.a, 2) ^ rotr(v.a, 13) ^ rotr(v.a, 22))
             + ((v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c));

   always_comb begin
      rounded       = data_ff;
      rounded.sched = {data_ff.sched[479:0], w_new};
      rounded.work  = '{t1 + t2, v.a, v.b, v.c, v.d + t1, v.e, v.f, v.g};
   end

   always_comb begin
      data_in = data_ff;
      if (advance) begin
         data_in = prev_data;
      end else if (step_en && data_ff.valid) begin
         data_in = rounded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) data_ff.valid <= 1'b0;
      else       data_ff.valid <= data_in.valid;
      data_ff.batch <= data_in.batch;
      data_ff.sched <= data_in.sched;
      data_ff.work  <= data_in.work;
   end

   // The eighth round is done on the way out, as the neighbor loads it at the shift.
   assign cell_data = rounded;
endmodule

// File: rtl/core/smhh_emit.sv
// Cuts the digest into hex pieces and reduces each one by a bit-serial remainder.
module smhh_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [255:0]            in_digest,
   input  logic                    in_batch,
   input  logic [30:0]             mod_n,
   input  logic [6:0]              vlen,
   smhh_rsp_if.source              rsp
);
   import smhh_pkg::*;

   logic         busy_ff, busy_in;
   logic [255:0] dig_ff, dig_in;
   logic         batch_ff, batch_in;
   logic [30:0]  n_ff, n_in;
   logic [3:0]   plen_ff, plen_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [5:0]   slot_ff, slot_in;
   logic         red_ff, red_in;
   logic [31:0]  val_ff, val_in;
   logic [31:0]  rem_ff, rem_in;
   logic [5:0]   bit_ff, bit_in;
   logic         oval_ff, oval_in;
   logic [30:0]  oidx_ff, oidx_in;
   logic [5:0]   oslot_ff, oslot_in;
   logic         olast_ff, olast_in;
   logic         obatch_ff, obatch_in;
   logic [30:0]  n_eff;
   logic [4:0]   lg;
   logic [3:0]   plen;
   logic [6:0]   maxc, cnt_c;
   logic [31:0]  piece, shl;
   logic [32:0]  trial;

   assign n_eff = (mod_n == '0) ? 31'd1 : mod_n;
   always_comb begin
      int k;
      lg = '0;
      for (k = 1; k < 31; k++) if (n_eff[k]) lg = 5'(k);
   end
   assign plen = 4'd1 + 4'(lg >> 2);
   always_comb begin
      unique case (plen)
         4'd1: maxc = 7'd64;
         4'd2: maxc = 7'd32;
         4'd3: maxc = 7'd21;
         4'd4: maxc = 7'd16;
         4'd5: maxc = 7'd12;
         4'd6: maxc = 7'd10;
         4'd7: maxc = 7'd9;
         4'd8: maxc = 7'd8;
         default: maxc = 7'd8;
      endcase
      cnt_c = (vlen == '0) ? 7'd1 : vlen;
      if (cnt_c > maxc) cnt_c = maxc;
   end

   always_comb begin
      piece = dig_ff[255 -: 32] >> (32 - 4 * int'(plen_ff));
   end
   assign shl   = {rem_ff[30:0], val_ff[bit_ff[4:0]]};
   assign trial = {1'b0, shl} - {2'b0, n_ff};

   assign in_ready = !busy_ff;

   always_comb begin
      busy_in = busy_ff; dig_in = dig_ff; batch_in = batch_ff; n_in = n_ff;
      plen_in = plen_ff; cnt_in = cnt_ff; slot_in = slot_ff; red_in = red_ff;
      val_in = val_ff; rem_in = rem_ff; bit_in = bit_ff;
      oval_in = oval_ff; oidx_in = oidx_ff; oslot_in = oslot_ff;
      olast_in = olast_ff; obatch_in = obatch_ff;
      if (oval_ff && rsp.ready) oval_in = 1'b0;
      if (!busy_ff) begin
         if (in_valid) begin
            busy_in = 1'b1; dig_in = in_digest; batch_in = in_batch;
            n_in = n_eff; plen_in = plen; cnt_in = 6'(cnt_c - 7'd1);
            slot_in = '0; red_in = 1'b0;
         end
      end else if (!red_ff) begin
         val_in = piece;
         dig_in = dig_ff << (4 * int'(plen_ff));
         rem_in = '0;
         bit_in = 6'd31;
         red_in = 1'b1;
      end else if (bit_ff != 6'd63) begin
         rem_in = trial[32] ? shl : trial[31:0];
         bit_in = bit_ff - 6'd1;
      end else if (!oval_ff || rsp.ready) begin
         oval_in = 1'b1; oidx_in = rem_ff[30:0]; oslot_in = slot_ff;
         olast_in = (slot_ff == cnt_ff); obatch_in = batch_ff;
         red_in = 1'b0;
         slot_in = slot_ff + 6'd1;
         if (slot_ff == cnt_ff) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         oval_ff <= 1'b0;
         red_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         oval_ff <= oval_in;
         red_ff  <= red_in;
      end
      dig_ff <= dig_in; batch_ff <= batch_in; n_ff <= n_in; plen_ff <= plen_in;
      cnt_ff <= cnt_in; slot_ff <= slot_in; val_ff <= val_in; rem_ff <= rem_in;
      bit_ff <= bit_in; oidx_ff <= oidx_in; oslot_ff <= oslot_in;
      olast_ff <= olast_in; obatch_ff <= obatch_in;
   end

   assign rsp.valid      = oval_ff;
   assign rsp.index      = oidx_ff;
   assign rsp.slot       = oslot_ff;
   assign rsp.last       = olast_ff;
   assign rsp.batch_last = obatch_ff;
endmodule

// File: rtl/core/sha256_multi_hot_hasher.sv
// SHA-256 multi-hot hasher: a request becomes a padded block at one decimal digit per cycle,
// then passes a chain of eight compression cells, each doing eight rounds, so up to eight
// requests hash at once. Each result then goes through the bit-serial modulo unit, which
// sets the sustained rate: it takes no new digest until it has emitted every piece, one per
// vector slot, with the vector length clamped to 64 / piece length.
module sha256_multi_hot_hasher (
   input  logic             clock,
   input  logic             reset,
   smhh_req_if.sink         req,
   smhh_rsp_if.source       rsp,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [30:0]      csr_wdata
);
   import smhh_pkg::*;

   logic [30:0]  mod_n_ff;
   logic [6:0]   vlen_ff;
   logic         m_valid, m_ready, m_batch;
   logic [511:0] m_block;
   logic [2:0]   step_ff;
   logic         advance, tail_busy, e_ready;
   cell_data_type chain [NUM_CELLS+1];
   cell_data_type head;
   work_type     fin;
   logic [255:0] digest;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_n_ff <= 31'd1000;
         vlen_ff  <= 7'd10;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MOD_N: mod_n_ff <= csr_wdata;
            CSR_VLEN:  vlen_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   smhh_msg u_msg (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .in_value(req.value), .in_batch(req.batch_end), .out_valid(m_valid),
      .out_ready(m_ready), .out_block(m_block), .out_batch(m_batch));

   // Cells step together; the chain shifts when the step counter is at its last step and the tail can leave.
   assign tail_busy = chain[NUM_CELLS].valid && !e_ready;
   assign advance   = (step_ff == 3'd7) && !tail_busy;
   assign m_ready   = advance;

   always_ff @(posedge clock) begin
      if (reset)             step_ff <= '0;
      else if (step_ff != 3'd7 || advance) step_ff <= step_ff + 3'd1;
   end

   always_comb begin
      head.valid = m_valid;
      head.batch = m_batch;
      head.sched = m_block;
      head.work  = INIT_H;
   end
   assign chain[0] = head;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      smhh_cell u_cell (
         .clock(clock), .reset(reset), .cell_id(3'(g)), .advance(advance),
         .step_en(step_ff != 3'd7),
         .step(step_ff), .prev_data(chain[g]), .cell_data(chain[g+1]));
   end

   assign fin    = chain[NUM_CELLS].work;
   assign digest = {fin.a + INIT_H.a, fin.b + INIT_H.b, fin.c + INIT_H.c, fin.d + INIT_H.d,
                    fin.e + INIT_H.e, fin.f + INIT_H.f, fin.g + INIT_H.g, fin.h + INIT_H.h};

   smhh_emit u_emit (
      .clock(clock), .reset(reset), .in_valid(chain[NUM_CELLS].valid && advance),
      .in_ready(e_ready), .in_digest(digest), .in_batch(chain[NUM_CELLS].batch),
      .mod_n(mod_n_ff), .vlen(vlen_ff), .rsp(rsp));
endmodule

// File: rtl/core/smhh_checker.sv
// Port-level checker for the hasher, bound to the top level.
module smhh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_slot,
   input logic        rsp_last,
   input logic [30:0] rsp_index
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last ##1 rsp_valid |-> rsp_slot == 6'd0)
      else $error("vector did not restart at slot zero");
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind sha256_multi_hot_hasher smhh_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_slot(rsp.slot), .rsp_last(rsp.last), .rsp_index(rsp.index));

// File: sim/smhh_tb_if.sv
// The testbench uses the channel interfaces declared with the block; none are declared here.

// File: sim/sha256_multi_hot_hasher_tb.sv
// Testbench for the SHA-256 multi-hot hasher: random and directed requests, scoreboard check.
module sha256_multi_hot_hasher_tb;
   import smhh_pkg::*;

   typedef struct packed {
      logic [30:0] index;
      logic [5:0]  slot;
      logic        last;
      logic        batch_last;
   } hot_index_type;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [255:0] digest_of_text(logic [7:0] text [12], int len);
      logic [7:0]  blk [64];
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] h0 [8];
      logic [31:0] kk [64];
      logic [31:0] s0, s1, t1, t2;
      logic [255:0] dg;
      h0 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      kk = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
             32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
             32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
             32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
             32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
             32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
             32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
             32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
             32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
             32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
             32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
             32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
             32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      for (int i = 0; i < len; i++) blk[i] = text[i];
      blk[len] = 8'h80;
      blk[63] = 8'(len * 8);
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      v = h0;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kk[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) dg[255 - 32*i -: 32] = h0[i] + v[i];
      return dg;
   endfunction

   class hot_index_board;
      hot_index_type pending [$];
      logic [30:0] modulus = 31'd1000;
      logic [6:0]  vec_len = 7'd10;
      int errors = 0;

      function void note_request(logic [31:0] raw, logic batch);
         logic [7:0] text [12];
         logic [7:0] rev [10];
         logic [31:0] mag, n, val;
         logic [255:0] dg;
         hot_index_type r;
         int len, nd, lg, piece, count;
         len = 0; nd = 0; lg = 0;
         n = (modulus == 0) ? 32'd1 : {1'b0, modulus};
         if (raw[31]) begin
            text[len++] = "-";
            mag = -raw;
         end else mag = raw;
         do begin
            rev[nd++] = 8'(8'h30 + mag % 10);
            mag = mag / 10;
         end while (mag != 0 && nd < 10);
         while (nd > 0) text[len++] = rev[--nd];
         dg = digest_of_text(text, len);
         for (logic [31:0] t = n; t > 1; t = t >> 1) lg++;
         piece = 1 + lg / 4;
         count = (vec_len == 0) ? 1 : vec_len;
         if (count > 64 / piece) count = 64 / piece;
         for (int j = 0; j < count; j++) begin
            val = 0;
            for (int d = 0; d < piece; d++)
               val = (val << 4) | 32'(dg[255 - 4*(j*piece + d) -: 4]);
            r.index = 31'(val % n);
            r.slot = 6'(j);
            r.last = (j + 1 == count);
            r.batch_last = batch;
            pending.push_back(r);
         end
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(hot_index_type got);
         hot_index_type exp;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
         end
         exp = pending.pop_front();
         if (got.index != exp.index)
            report($sformatf("index %0d, wanted %0d", got.index, exp.index));
         if (got.slot != exp.slot)
            report($sformatf("slot %0d, wanted %0d", got.slot, exp.slot));
         if (got.last != exp.last)
            report($sformatf("last %0b, wanted %0b", got.last, exp.last));
         if (got.batch_last != exp.batch_last)
            report($sformatf("batch_last %0b, wanted %0b", got.batch_last, exp.batch_last));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [0:0] csr_index = 0;
   logic [30:0] csr_wdata = 0;
   int cycle_count = 0;
   hot_index_board board = new();

   smhh_req_if req ();
   smhh_rsp_if rsp ();

   sha256_multi_hot_hasher DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      req.valid = 0;
      req.value = 0;
      req.batch_end = 0;
      rsp.ready = 0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sink side: random stalls, checks every accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready)
            board.check_result('{rsp.index, rsp.slot, rsp.last, rsp.batch_last});
         rsp.ready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("[sha256_multi_hot_hasher] ERROR");
         $finish;
      end
   end

   // Valid stays high after acceptance, carrying the next request, unless a gap follows.
   task automatic send_request(logic [31:0] v, logic b);
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req.valid <= 1;
      req.value <= v;
      req.batch_end <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(v, b);
   endtask

   task automatic write_csr(csr_index_type idx, logic [30:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_MOD_N) board.modulus = data;
      else board.vec_len = data[6:0];
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      logic [31:0] v;
      logic [30:0] mods [6];
      logic [6:0]  lens [6];
      mods = '{31'd1000, 31'd0, 31'd1, 31'h7fffffff, 31'd16, 31'd65536};
      lens = '{7'd10, 7'd0, 7'd64, 7'd1, 7'd127, 7'd5};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: field extremes under the reset settings.
      send_request(32'h0, 0);
      send_request(32'h7fffffff, 1);
      send_request(32'h80000000, 0);
      send_request(32'hffffffff, 1);
      send_request(32'd9, 0);
      send_request(32'd10, 1);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_MOD_N, mods[ph]);
         write_csr(CSR_VLEN, {24'd0, lens[ph]});
         send_request(32'h80000000, 1);
         send_request(32'h7fffffff, 0);
         for (int i = 0; i < 16; i++) begin
            case ($urandom_range(0, 3))
               0: v = $urandom_range(0, 999);
               1: v = -$urandom_range(1, 999);
               default: v = $urandom;
            endcase
            send_request(v, 1'($urandom_range(0, 1)));
         end
         drain();
      end
      if (board.errors == 0)
         $display("[sha256_multi_hot_hasher] OK");
      else
         $display("[sha256_multi_hot_hasher] ERROR");
      $finish;
   end
endmodule
